### rtl/pidl_pkg.sv
// pidl_pkg: shared types and constants for the positional insert/delete list
// holds operation and status codes and the command struct broadcast to the cells
// no dependencies
package pidl_pkg;

   localparam int POS_W   = 7;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2
   } pidl_op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_INS_REFUSED = 2'd1,
      ST_REM_REFUSED = 2'd2,
      ST_RD_REFUSED  = 2'd3
   } pidl_status_type;

   // command seen by every cell in the cycle a request is accepted
   typedef struct packed {
      logic             ins;
      logic             rem;
      logic             rd;
      logic [POS_W-1:0] pos;
   } pidl_cmd_type;

endpackage

### rtl/pidl_cell.sv
// pidl_cell: one list slot of the cell chain
// shifts up or down with its neighbors, loads a new word, taps out on read
// depends on pidl_pkg
module pidl_cell #(
   parameter int EW    = 32,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  pidl_pkg::pidl_cmd_type cmd,
   input  logic [EW-1:0]         word,
   input  logic [EW-1:0]         lower_in,
   input  logic [EW-1:0]         upper_in,
   output logic [EW-1:0]         data_out,
   output logic [EW-1:0]         tap_out
);
   import pidl_pkg::*;

   logic [EW-1:0] data_ff, data_in;
   logic [EW-1:0] tap_ff, tap_in;
   logic [31:0]   pos_w;
   logic          hit;
   logic          below;

   assign pos_w = 32'(cmd.pos);
   assign hit   = (pos_w == 32'(INDEX));
   assign below = (pos_w < 32'(INDEX));

   always_comb begin
      priority if (cmd.ins && below) begin
         data_in = lower_in;
      end else if (cmd.ins && hit) begin
         data_in = word;
      end else if (cmd.rem && (below || hit)) begin
         data_in = upper_in;
      end else begin
         data_in = data_ff;
      end
      tap_in = (cmd.rd && hit) ? data_ff : '0;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tap_ff  <= tap_in;
   end

   assign data_out = data_ff;
   assign tap_out  = tap_ff;

endmodule

### rtl/pidl_or_tree.sv
// pidl_or_tree: registered 4-ary or-reduction of the cell read taps
// one register level per tree level, from leaves to root
// depends on pidl_pkg
module pidl_or_tree #(
   parameter int EW     = 32,
   parameter int LEVELS = 3
) (
   input  logic          clock,
   input  logic [EW-1:0] leaf_in [1 << (2*LEVELS)],
   output logic [EW-1:0] root_out
);
   import pidl_pkg::*;

   localparam int LEAVES = 1 << (2*LEVELS);
   localparam int NODES  = (LEAVES - 1) / 3;
   localparam int TOTAL  = NODES + LEAVES;

   logic [EW-1:0] node_ff [NODES];
   logic [EW-1:0] all_w   [TOTAL];

   // heap order: children of node k sit at 4k+1 .. 4k+4
   always_comb begin
      for (int k = 0; k < NODES; k++) begin
         all_w[k] = node_ff[k];
      end
      for (int j = 0; j < LEAVES; j++) begin
         all_w[NODES+j] = leaf_in[j];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NODES; k++) begin
         node_ff[k] <= all_w[4*k+1] | all_w[4*k+2] | all_w[4*k+3] | all_w[4*k+4];
      end
   end

   assign root_out = node_ff[0];

endmodule

### rtl/positional_insert_delete_list.sv
// positional_insert_delete_list: bounded ordered list with positional insert,
// remove and read, built as a chain of cells plus a registered read tree
// depends on pidl_pkg, pidl_cell, pidl_or_tree
//
// usage
//   request channel: req_valid / req_stall with req_operation, req_position,
//   req_entry_data. a request is taken on a clock edge with req_valid high
//   and req_stall low
//   response channel: rsp_valid / rsp_stall with rsp_status, rsp_read_data,
//   rsp_entry_count, one response per request, in request order
//   insert and remove move every later entry one cell in the cycle the
//   request is taken; a read collects the addressed cell through a 4-ary
//   registered or-tree of L = ceil(log4(DEPTH)) levels (3 at DEPTH 64)
//   a request is held while the cell tap register and the L tree levels drain,
//   then its response is registered; no new request is taken while one is in flight.
//   a new request is taken in the same cycle the previous response leaves
//   the depth of the read tree sets how long each request is in flight
//   receiver stall: the response register holds its value and req_stall
//   stays high until the response is taken
//   reset: synchronous, clears the entry count and all handshake state;
//   list cells need no clearing since only entries below the count are read
module positional_insert_delete_list #(
   parameter int DEPTH       = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [pidl_pkg::POS_W-1:0]   req_position,
   input  logic [pidl_pkg::DATA_W-1:0]  req_entry_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [pidl_pkg::DATA_W-1:0]  rsp_read_data,
   output logic [pidl_pkg::COUNT_W-1:0] rsp_entry_count
);
   import pidl_pkg::*;

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int MW     = (CW > POS_W) ? CW : POS_W;
   localparam int LEVELS = ($clog2(DEPTH) + 1) / 2;
   localparam int LEAVES = 1 << (2*LEVELS);
   localparam int CNTW   = $clog2(LEVELS + 1);

   // control state
   logic [CW-1:0]    count_ff, count_in;
   logic             busy_ff, busy_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload held for the response
   pidl_status_type  status_pend_ff, status_pend_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_read_data_ff, rsp_read_data_in;
   logic [COUNT_W-1:0] rsp_entry_count_ff, rsp_entry_count_in;

   logic             accept;
   logic             done;
   logic             ok;
   pidl_status_type  status_now;
   logic [MW-1:0]    pos_m;
   logic [MW-1:0]    cnt_m;
   logic             full;
   pidl_cmd_type     cmd;
   logic [63:0]      word_wide;
   logic [ENTRY_WIDTH-1:0] word;
   logic [ENTRY_WIDTH-1:0] chain_w [DEPTH+2];
   logic [ENTRY_WIDTH-1:0] taps_w  [LEAVES];
   logic [ENTRY_WIDTH-1:0] root_w;
   logic [63:0]      root_wide;

   // take a request only when nothing is in flight and the response slot frees up
   assign req_stall = busy_ff | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign done      = busy_ff && (cnt_ff == '0);

   assign pos_m = MW'(req_position);
   assign cnt_m = MW'(count_ff);
   assign full  = (count_ff == CW'(DEPTH));

   // admission check against the count before this request
   always_comb begin
      ok         = 1'b0;
      status_now = ST_RD_REFUSED;
      unique case (req_operation)
         OP_INSERT: begin
            ok         = !full && (pos_m <= cnt_m);
            status_now = ok ? ST_OK : ST_INS_REFUSED;
         end
         OP_REMOVE: begin
            ok         = (pos_m < cnt_m);
            status_now = ok ? ST_OK : ST_REM_REFUSED;
         end
         OP_READ: begin
            ok         = (pos_m < cnt_m);
            status_now = ok ? ST_OK : ST_RD_REFUSED;
         end
         default: begin
            // unused code behaves as a refused read
            ok         = 1'b0;
            status_now = ST_RD_REFUSED;
         end
      endcase
   end

   // broadcast to the cells, live only in the accept cycle
   always_comb begin
      cmd.ins = accept && ok && (req_operation == OP_INSERT);
      cmd.rem = accept && ok && (req_operation == OP_REMOVE);
      cmd.rd  = accept && ok && (req_operation == OP_READ);
      cmd.pos = req_position;
   end

   // entry word kept to ENTRY_WIDTH bits, zero above the port width
   assign word_wide = 64'(req_entry_data);
   assign word      = word_wide[ENTRY_WIDTH-1:0];

   // the cell chain, zero words feed both open ends
   assign chain_w[0]       = '0;
   assign chain_w[DEPTH+1] = '0;

   for (genvar i = 0; i < LEAVES; i++) begin : g_slot
      if (i < DEPTH) begin : g_cell
         pidl_cell #(
            .EW    (ENTRY_WIDTH),
            .INDEX (i)
         ) u_cell (
            .clock    (clock),
            .cmd      (cmd),
            .word     (word),
            .lower_in (chain_w[i]),
            .upper_in (chain_w[i+2]),
            .data_out (chain_w[i+1]),
            .tap_out  (taps_w[i])
         );
      end else begin : g_pad
         assign taps_w[i] = '0;
      end
   end

   // read data: only the addressed cell taps out, all others give zero
   pidl_or_tree #(
      .EW     (ENTRY_WIDTH),
      .LEVELS (LEVELS)
   ) u_tree (
      .clock    (clock),
      .leaf_in  (taps_w),
      .root_out (root_w)
   );

   assign root_wide = 64'(root_w);

   // sequencing: count update on accept, response built when the tree drains
   always_comb begin
      count_in           = count_ff;
      busy_in            = busy_ff;
      cnt_in             = cnt_ff;
      rsp_valid_in       = rsp_valid_ff;
      status_pend_in     = status_pend_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_read_data_in   = rsp_read_data_ff;
      rsp_entry_count_in = rsp_entry_count_ff;

      if (accept) begin
         busy_in        = 1'b1;
         cnt_in         = CNTW'(LEVELS);
         status_pend_in = status_now;
         if (cmd.ins) begin
            count_in = count_ff + 1'b1;
         end else if (cmd.rem) begin
            count_in = count_ff - 1'b1;
         end
      end else if (busy_ff && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - 1'b1;
      end

      priority if (done) begin
         busy_in            = 1'b0;
         rsp_valid_in       = 1'b1;
         rsp_status_in      = status_pend_ff;
         rsp_read_data_in   = root_wide[DATA_W-1:0];
         rsp_entry_count_in = COUNT_W'(count_ff);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_pend_ff     <= status_pend_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_read_data_ff   <= rsp_read_data_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

`ifndef SYNTHESIS
   // the list never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // a refused request leaves the count alone
   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      (accept && !ok) |=> $stable(count_ff))
      else $error("refused request changed the count");

   // a response only appears when the read tree has drained
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("response without a request in flight");

   // a refused response carries zero data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_read_data_ff == '0))
      else $error("refused response carries data");
`endif

endmodule
